FILE: hdl/ftba_pkg.sv
// Shared types and constants of the feathered tile blend accumulator.
// Used by the divider, the top level and the testbench.
`default_nettype none
package ftba_pkg;

  localparam int OUT_WIDTH     = 256;
  localparam int OUT_HEIGHT    = 256;
  localparam int CHANNELS      = 3;
  localparam int MAX_TILE_SIDE = 1024;

  localparam int PIX_DEPTH = OUT_WIDTH * OUT_HEIGHT;
  localparam int SUM_DEPTH = PIX_DEPTH * CHANNELS;
  localparam int PIX_AW    = $clog2(PIX_DEPTH);
  localparam int SUM_AW    = $clog2(SUM_DEPTH);
  localparam int CLR_W     = $clog2(SUM_DEPTH + 1);

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [23:0] WSUM_MAX = 24'hFFFFFF;

  localparam logic [5:0] DIV_SHORT_STEPS = 6'd24;
  localparam logic [5:0] DIV_LONG_STEPS  = 6'd48;

  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic        start;
    logic        short_div;
    logic [47:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/ftba_if.sv
// Valid/ready channel interfaces for input words, result words and configuration.
// Depends on no other file; the interfaces do not use the package.
`default_nettype none
interface ftba_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [1:0]         channel;
  logic [7:0]         origin_row;
  logic [7:0]         origin_col;
  logic [9:0]         local_row;
  logic [9:0]         local_col;
  logic [10:0]        tile_height;
  logic [10:0]        tile_width;
  logic signed [19:0] value;
  modport source(output valid, func, channel, origin_row, origin_col, local_row, local_col,
                 tile_height, tile_width, value, input ready);
  modport sink(input valid, func, channel, origin_row, origin_col, local_row, local_col,
               tile_height, tile_width, value, output ready);
endinterface

interface ftba_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] pixel_out;
  logic               uncovered;
  modport source(output valid, pixel_out, uncovered, input ready);
  modport sink(input valid, pixel_out, uncovered, output ready);
endinterface

interface ftba_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] feather_width;
  modport source(output valid, feather_width, input ready);
  modport sink(input valid, feather_width, output ready);
endinterface
`default_nettype wire

FILE: hdl/ftba_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Uses ftba_pkg request and response structs; 24 or 48 steps per division.
`default_nettype none
module ftba_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ftba_pkg::div_req_t req,
  output ftba_pkg::div_rsp_t      rsp
);

  logic        busy_r, done_r, short_r;
  logic [5:0]  cnt_r;
  logic [23:0] rem_r, dvs_r, rem_nxt;
  logic [47:0] dq_r;
  logic [24:0] rem2, diff;
  logic        ge;

  assign rem2    = {rem_r, dq_r[47]};
  assign diff    = rem2 - {1'b0, dvs_r};
  assign ge      = rem2 >= {1'b0, dvs_r};
  assign rem_nxt = ge ? diff[23:0] : rem2[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_div ? ftba_pkg::DIV_SHORT_STEPS : ftba_pkg::DIV_LONG_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r   <= '0;
      dvs_r   <= req.divisor;
      short_r <= req.short_div;
      dq_r    <= req.short_div ? {req.dividend[23:0], 24'd0} : req.dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= {dq_r[46:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = short_r ? {24'd0, dq_r[23:0]} : dq_r;

endmodule
`default_nettype wire

FILE: hdl/feathered_tile_blend_accumulator.sv
// Accumulate word: each of the four feather factors passes S_FACT and S_FMUL, with a
// 24-step divide in S_FDIV between them when needed; then S_ARD, S_AWR and input is ready.
// Readout: S_PUT if out of range; else S_RRD, S_RDAT and, if covered, a 48-step sum divide.
// A finished result moves to the output register; it waits only while that register is full.
// After reset a clearing pass zeroes both memories; input is held off.
// Configuration writes are taken in every cycle.
`default_nettype none
module feathered_tile_blend_accumulator (
  input  wire logic clk,
  input  wire logic rst_n,
  ftba_in_if.sink   in_ch,
  ftba_out_if.source out_ch,
  ftba_cfg_if.sink  cfg_ch
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FACT  = 4'd2;
  localparam logic [3:0] S_FDIV  = 4'd3;
  localparam logic [3:0] S_FMUL  = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_AWR   = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_RDAT  = 4'd8;
  localparam logic [3:0] S_RDIV  = 4'd9;
  localparam logic [3:0] S_PUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [ftba_pkg::CLR_W-1:0] clr_r;
  logic [7:0] fw_r;
  logic [1:0] idx_r;
  logic [1:0] ch_r;
  logic [10:0] k0_r, k1_r, k2_r, k3_r, k_sel;
  logic signed [19:0] val_r;
  logic [16:0] w_r, f_r;
  logic [33:0] wf_prod;
  logic signed [37:0] prod_r;
  logic [ftba_pkg::PIX_AW-1:0] pix_r;
  logic [ftba_pkg::SUM_AW-1:0] sadr_r;
  logic neg_r;
  logic out_valid_r;
  logic signed [19:0] res_r, res_nxt;
  logic unc_r, unc_nxt;
  logic signed [19:0] out_res_r;
  logic out_unc_r;
  logic put_fire;

  logic [47:0] sum_mem [ftba_pkg::SUM_DEPTH];
  logic [23:0] wgt_mem [ftba_pkg::PIX_DEPTH];
  logic [47:0] sum_rd_r;
  logic [23:0] wgt_rd_r;
  logic        sum_we, wgt_we;
  logic [ftba_pkg::SUM_AW-1:0] sum_wa;
  logic [ftba_pkg::PIX_AW-1:0] wgt_wa;
  logic [47:0] sum_wd;
  logic [23:0] wgt_wd;

  ftba_pkg::div_req_t dreq;
  ftba_pkg::div_rsp_t drsp;

  logic        accept;
  logic [10:0] a_row, a_col;
  logic        acc_ok, rd_ok;
  logic [ftba_pkg::PIX_AW-1:0] a_pix;
  logic [ftba_pkg::SUM_AW-1:0] a_sadr;
  logic signed [48:0] acc_sum;
  logic [47:0] acc_sat;
  logic [24:0] wsum;
  logic [47:0] mag, qm;

  ftba_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign put_fire     = (state_r == S_PUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (in_ch.func == ftba_pkg::FUNC_READ) begin
      a_row = {3'd0, in_ch.origin_row};
      a_col = {3'd0, in_ch.origin_col};
    end else begin
      a_row = {3'd0, in_ch.origin_row} + {1'b0, in_ch.local_row};
      a_col = {3'd0, in_ch.origin_col} + {1'b0, in_ch.local_col};
    end
    a_pix  = ftba_pkg::PIX_AW'(32'(a_row) * ftba_pkg::OUT_WIDTH + 32'(a_col));
    a_sadr = ftba_pkg::SUM_AW'(32'(a_pix) * ftba_pkg::CHANNELS + 32'(in_ch.channel));
    rd_ok  = (32'(in_ch.channel) < ftba_pkg::CHANNELS) &&
             (32'(a_row) < ftba_pkg::OUT_HEIGHT) && (32'(a_col) < ftba_pkg::OUT_WIDTH);
    acc_ok = rd_ok && (in_ch.tile_height != 11'd0) && (in_ch.tile_width != 11'd0) &&
             (32'(in_ch.tile_height) <= ftba_pkg::MAX_TILE_SIDE) &&
             (32'(in_ch.tile_width) <= ftba_pkg::MAX_TILE_SIDE) &&
             ({1'b0, in_ch.local_row} < in_ch.tile_height) &&
             ({1'b0, in_ch.local_col} < in_ch.tile_width);
  end

  always_comb begin
    case (idx_r)
      2'd0:    k_sel = k0_r;
      2'd1:    k_sel = k1_r;
      2'd2:    k_sel = k2_r;
      default: k_sel = k3_r;
    endcase
  end

  assign wf_prod = w_r * f_r;
  assign acc_sum = 49'(signed'(sum_rd_r)) + 49'(prod_r);
  assign acc_sat = (acc_sum[48] != acc_sum[47]) ?
                   (acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : acc_sum[47:0];
  assign wsum    = {1'b0, wgt_rd_r} + {8'd0, w_r};
  assign mag     = sum_rd_r[47] ? (48'd0 - sum_rd_r) : sum_rd_r;
  assign qm      = drsp.quotient;

  always_comb begin
    dreq.start     = 1'b0;
    dreq.short_div = 1'b1;
    dreq.dividend  = {24'd0, k_sel[7:0], 16'd0};
    dreq.divisor   = {16'd0, fw_r};
    if (state_r == S_RDAT) begin
      dreq.short_div = 1'b0;
      dreq.dividend  = mag;
      dreq.divisor   = wgt_rd_r;
      dreq.start     = (wgt_rd_r != 24'd0);
    end else if (state_r == S_FACT) begin
      dreq.start = (fw_r != 8'd0) && (k_sel <= {3'd0, fw_r});
    end
  end

  always_comb begin
    sum_we = 1'b0;
    wgt_we = 1'b0;
    sum_wa = sadr_r;
    wgt_wa = pix_r;
    sum_wd = '0;
    wgt_wd = '0;
    case (state_r)
      S_CLEAR: begin
        sum_we = 1'b1;
        sum_wa = ftba_pkg::SUM_AW'(clr_r);
        wgt_we = (32'(clr_r) < ftba_pkg::PIX_DEPTH);
        wgt_wa = ftba_pkg::PIX_AW'(clr_r);
      end
      S_AWR: begin
        sum_we = 1'b1;
        sum_wd = acc_sat;
        wgt_we = (ch_r == 2'd0);
        wgt_wd = wsum[24] ? ftba_pkg::WSUM_MAX : wsum[23:0];
      end
      S_RDAT: begin
        sum_we = 1'b1;
        wgt_we = (32'(ch_r) == ftba_pkg::CHANNELS - 1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd_r <= sum_mem[sadr_r];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) begin
      wgt_mem[wgt_wa] <= wgt_wd;
    end
    wgt_rd_r <= wgt_mem[pix_r];
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    unc_nxt   = unc_r;
    case (state_r)
      S_CLEAR: begin
        if (32'(clr_r) == ftba_pkg::SUM_DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.func == ftba_pkg::FUNC_READ) begin
            if (rd_ok) begin
              state_nxt = S_RRD;
            end else begin
              res_nxt   = '0;
              unc_nxt   = 1'b1;
              state_nxt = S_PUT;
            end
          end else if (acc_ok) begin
            state_nxt = S_FACT;
          end
        end
      end
      S_FACT:  state_nxt = dreq.start ? S_FDIV : S_FMUL;
      S_FDIV:  state_nxt = drsp.done ? S_FMUL : S_FDIV;
      S_FMUL:  state_nxt = (idx_r == 2'd3) ? S_ARD : S_FACT;
      S_ARD:   state_nxt = S_AWR;
      S_AWR:   state_nxt = S_IDLE;
      S_RRD:   state_nxt = S_RDAT;
      S_RDAT: begin
        if (wgt_rd_r == 24'd0) begin
          res_nxt   = '0;
          unc_nxt   = 1'b1;
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (drsp.done) begin
          unc_nxt = 1'b0;
          if (neg_r) begin
            res_nxt = (qm > 48'd524288) ? 20'sh80000 : signed'(20'(48'd0 - qm));
          end else begin
            res_nxt = (qm > 48'd524287) ? 20'sh7FFFF : signed'(qm[19:0]);
          end
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (put_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + ftba_pkg::CLR_W'(1);
      end
      if (cfg_ch.valid) begin
        fw_r <= cfg_ch.feather_width;
      end
      if (put_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    unc_r <= unc_nxt;
    if (put_fire) begin
      out_res_r <= res_r;
      out_unc_r <= unc_r;
    end
    if (accept) begin
      ch_r   <= in_ch.channel;
      val_r  <= in_ch.value;
      pix_r  <= a_pix;
      sadr_r <= a_sadr;
      k0_r   <= {1'b0, in_ch.local_row} + 11'd1;
      k1_r   <= in_ch.tile_height - {1'b0, in_ch.local_row};
      k2_r   <= {1'b0, in_ch.local_col} + 11'd1;
      k3_r   <= in_ch.tile_width - {1'b0, in_ch.local_col};
      w_r    <= ftba_pkg::ONE_Q16;
      idx_r  <= 2'd0;
    end
    if (state_r == S_FACT && !dreq.start) begin
      f_r <= ftba_pkg::ONE_Q16;
    end
    if (state_r == S_FDIV && drsp.done) begin
      f_r <= qm[16:0];
    end
    if (state_r == S_FMUL) begin
      w_r   <= wf_prod[32:16];
      idx_r <= idx_r + 2'd1;
    end
    if (state_r == S_ARD) begin
      prod_r <= 38'(val_r) * signed'({1'b0, w_r});
    end
    if (state_r == S_RDAT) begin
      neg_r <= sum_rd_r[47];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_res_r;
  assign out_ch.uncovered = out_unc_r;

`ifndef NO_ASSERTIONS
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ch.ready)
    else $error("input taken during clearing pass");
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_FDIV || state_r == S_RDIV))
    else $error("divider finished outside a wait state");
  a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT))
    else $error("result word raised outside the output state");
  a_weight_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ARD |-> w_r <= ftba_pkg::ONE_Q16)
    else $error("feather weight above one");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/feathered_tile_blend_accumulator_tb.sv
// Testbench of the feathered tile blend accumulator: directed and random words through
// the valid/ready channels, checked against an in-bench predictor of the blended sums.
// Depends on ftba_pkg, the channel interfaces in hdl/ftba_if.sv and the top level.
`default_nettype none
module feathered_tile_blend_accumulator_tb;

  localparam logic signed [47:0] SUM_HI = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_LO = -48'sh7FFF_FFFF_FFFF - 48'sd1;

  typedef struct packed {
    logic        func;
    logic [1:0]  channel;
    logic [7:0]  origin_row;
    logic [7:0]  origin_col;
    logic [9:0]  local_row;
    logic [9:0]  local_col;
    logic [10:0] tile_height;
    logic [10:0] tile_width;
    logic signed [19:0] value;
  } pixel_word_t;

  typedef struct packed {
    logic signed [19:0] pixel_out;
    logic               uncovered;
  } blend_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ftba_in_if  in_ch();
  ftba_out_if out_ch();
  ftba_cfg_if cfg_ch();

  feathered_tile_blend_accumulator i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic signed [47:0] chan_sum [int];
  logic [23:0]        weight_total [int];
  logic [7:0]         feather;

  pixel_word_t pending_words[$];
  blend_word_t expected_pixels[$];
  int          mismatches = 0;
  bit          calm = 1'b0;
  bit          hold_results = 1'b0;
  bit          in_fire = 1'b0;
  int          drive_gap = 0;
  int          accept_gap = 0;

  function automatic void queue_word(input pixel_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic logic [16:0] edge_gain(input int k);
    if (feather == 8'd0 || k > feather) return ftba_pkg::ONE_Q16;
    return 17'((longint'(k) * 65536) / feather);
  endfunction

  function automatic void predict_blend(input pixel_word_t w);
    int row, col, key;
    longint gain, acc, quot;
    logic signed [47:0] s;
    logic [23:0] wt;
    blend_word_t r;
    if (w.func == ftba_pkg::FUNC_READ) begin
      r.pixel_out = '0;
      r.uncovered = 1'b1;
      if (w.channel < ftba_pkg::CHANNELS) begin
        key = w.origin_row * ftba_pkg::OUT_WIDTH + w.origin_col;
        s = chan_sum.exists(key * ftba_pkg::CHANNELS + w.channel) ?
            chan_sum[key * ftba_pkg::CHANNELS + w.channel] : '0;
        wt = weight_total.exists(key) ? weight_total[key] : '0;
        if (wt != 0) begin
          quot = longint'(s) / longint'(wt);
          if (quot > 524287) quot = 524287;
          if (quot < -524288) quot = -524288;
          r.pixel_out = 20'(quot);
          r.uncovered = 1'b0;
        end
        chan_sum[key * ftba_pkg::CHANNELS + w.channel] = '0;
        if (w.channel == ftba_pkg::CHANNELS - 1) weight_total[key] = '0;
      end
      expected_pixels = {expected_pixels, r};
      return;
    end
    if (w.channel >= ftba_pkg::CHANNELS) return;
    if (w.tile_height == 0 || w.tile_width == 0 || w.tile_height > ftba_pkg::MAX_TILE_SIDE ||
        w.tile_width > ftba_pkg::MAX_TILE_SIDE) return;
    if (w.local_row >= w.tile_height || w.local_col >= w.tile_width) return;
    row = w.origin_row + w.local_row;
    col = w.origin_col + w.local_col;
    if (row >= ftba_pkg::OUT_HEIGHT || col >= ftba_pkg::OUT_WIDTH) return;
    gain = 65536;
    gain = (gain * edge_gain(w.local_row + 1)) >> 16;
    gain = (gain * edge_gain(w.tile_height - w.local_row)) >> 16;
    gain = (gain * edge_gain(w.local_col + 1)) >> 16;
    gain = (gain * edge_gain(w.tile_width - w.local_col)) >> 16;
    key = row * ftba_pkg::OUT_WIDTH + col;
    s = chan_sum.exists(key * ftba_pkg::CHANNELS + w.channel) ?
        chan_sum[key * ftba_pkg::CHANNELS + w.channel] : '0;
    acc = longint'(s) + longint'(w.value) * gain;
    if (acc > longint'(SUM_HI)) acc = SUM_HI;
    if (acc < longint'(SUM_LO)) acc = SUM_LO;
    chan_sum[key * ftba_pkg::CHANNELS + w.channel] = 48'(acc);
    if (w.channel == 0) begin
      wt = weight_total.exists(key) ? weight_total[key] : '0;
      acc = longint'(wt) + gain;
      weight_total[key] = (acc > ftba_pkg::WSUM_MAX) ? ftba_pkg::WSUM_MAX : 24'(acc);
    end
  endfunction

  // Input driver: words leave the queue at the falling edge, with random gaps unless calm.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
    end else if (drive_gap > 0) begin
      drive_gap <= drive_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending_words.size() > 0) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        drive_gap <= $urandom_range(0, 5);
        in_ch.valid <= 1'b0;
      end else begin
        {in_ch.func, in_ch.channel, in_ch.origin_row, in_ch.origin_col, in_ch.local_row,
         in_ch.local_col, in_ch.tile_height, in_ch.tile_width, in_ch.value}
          <= pending_words.pop_front();
        in_ch.valid <= 1'b1;
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result ready with random stall bursts unless calm, or held off entirely.
  always @(negedge clk) begin
    if (hold_results) begin
      out_ch.ready <= 1'b0;
    end else if (accept_gap > 0) begin
      accept_gap <= accept_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      accept_gap <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts at input acceptance, checks at result acceptance.
  always @(posedge clk) begin
    blend_word_t want;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      predict_blend({in_ch.func, in_ch.channel, in_ch.origin_row, in_ch.origin_col,
                     in_ch.local_row, in_ch.local_col, in_ch.tile_height, in_ch.tile_width,
                     in_ch.value});
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: pixel_out=%0d uncovered=%0b",
                   out_ch.pixel_out, out_ch.uncovered);
      end else begin
        want = expected_pixels.pop_front();
        if (want.pixel_out !== out_ch.pixel_out || want.uncovered !== out_ch.uncovered) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected pixel_out=%0d uncovered=%0b, got %0d %0b",
                     want.pixel_out, want.uncovered, out_ch.pixel_out, out_ch.uncovered);
        end
      end
    end
  end

  function automatic pixel_word_t read_word(input int r, input int c, input int ch);
    pixel_word_t w;
    w = '0;
    w.func = ftba_pkg::FUNC_READ;
    w.channel = 2'(ch);
    w.origin_row = 8'(r);
    w.origin_col = 8'(c);
    w.local_row = 10'($urandom);
    w.local_col = 10'($urandom);
    w.tile_height = 11'($urandom);
    w.tile_width = 11'($urandom);
    w.value = 20'($urandom);
    return w;
  endfunction

  function automatic pixel_word_t acc_word(input int orow, input int ocol, input int lr,
                                           input int lc, input int th, input int tw,
                                           input int ch, input int v);
    pixel_word_t w;
    w.func = ftba_pkg::FUNC_ACC;
    w.channel = 2'(ch);
    w.origin_row = 8'(orow);
    w.origin_col = 8'(ocol);
    w.local_row = 10'(lr);
    w.local_col = 10'(lc);
    w.tile_height = 11'(th);
    w.tile_width = 11'(tw);
    w.value = 20'(v);
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_feather(input logic [7:0] f);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.feather_width <= f;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    feather = f;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // A tile of random size overlapping its neighbor, then readout of its pixels.
  task automatic queue_tile_burst(input bit noisy);
    int orow, ocol, th, tw, lr, lc, ch;
    orow = $urandom_range(0, 255);
    ocol = $urandom_range(0, 255);
    th = $urandom_range(1, 6);
    tw = $urandom_range(1, 6);
    for (int t = 0; t < 2; t++)
      for (int n = 0; n < 4; n++) begin
        lr = $urandom_range(0, th - 1);
        lc = $urandom_range(0, tw - 1);
        for (ch = 0; ch < ftba_pkg::CHANNELS; ch++)
          queue_word(acc_word(orow - t, ocol - t, lr + t, lc + t, th + t, tw + t,
                              ch, $urandom));
      end
    if (noisy)
      queue_word(acc_word($urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom));
    for (int n = 0; n < 3; n++)
      for (ch = 0; ch < ftba_pkg::CHANNELS; ch++)
        queue_word(read_word(orow + $urandom_range(0, th - 1),
                             ocol + $urandom_range(0, tw - 1), ch));
  endtask

  initial begin
    int phase_f [4];
    phase_f = '{0, 255, 1, 7};
    in_ch.valid = 1'b0;
    {in_ch.func, in_ch.channel, in_ch.origin_row, in_ch.origin_col, in_ch.local_row,
     in_ch.local_col, in_ch.tile_height, in_ch.tile_width, in_ch.value} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.feather_width = '0;
    feather = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_feather(8'd3);
    queue_word(acc_word(0, 0, 0, 0, 1, 1, 0, 20'sh7FFFF));
    queue_word(acc_word(0, 0, 0, 0, 1, 1, 1, -524288));
    queue_word(acc_word(0, 0, 0, 0, 1, 1, 2, 12345));
    queue_word(acc_word(250, 250, 5, 5, 10, 10, 0, 777));
    queue_word(acc_word(255, 255, 0, 0, 1024, 1024, 0, -1));
    queue_word(acc_word(255, 255, 1, 0, 1024, 1024, 0, 5));
    queue_word(acc_word(10, 10, 1023, 1023, 2047, 2047, 0, 5));
    queue_word(acc_word(10, 10, 0, 0, 0, 4, 0, 5));
    queue_word(acc_word(10, 10, 5, 0, 4, 4, 0, 5));
    queue_word(acc_word(10, 10, 0, 0, 4, 4, 3, 5));
    queue_word(acc_word(10, 10, 1, 1, 4, 4, 0, 300000));
    queue_word(read_word(0, 0, 0));
    queue_word(read_word(0, 0, 1));
    queue_word(read_word(0, 0, 2));
    queue_word(read_word(0, 0, 2));
    queue_word(read_word(255, 255, 0));
    queue_word(read_word(255, 255, 3));
    queue_word(read_word(11, 11, 0));
    queue_word(read_word(11, 11, 2));
    queue_word(read_word(200, 3, 1));
    wait_drained();

    // Saturation: repeated full-weight writes on one pixel.
    write_feather(8'd0);
    for (int n = 0; n < 260; n++)
      queue_word(acc_word(5, 5, 0, 0, 1, 1, 0, 20'sh7FFFF));
    queue_word(read_word(5, 5, 0));
    queue_word(read_word(5, 5, 2));
    // Long stall on the result side while readout words keep coming.
    for (int n = 0; n < 8; n++) queue_word(read_word(n, n, 1));
    while (pending_words.size() > 10) @(posedge clk);
    hold_results = 1'b1;
    repeat (600) @(posedge clk);
    hold_results = 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_feather(8'(phase_f[p]));
      for (int b = 0; b < 4; b++) queue_tile_burst(b % 3 == 0);
      if (p == 3) calm = 1'b1;
      wait_drained();
    end

    if (mismatches == 0)
      $display("** feathered_tile_blend_accumulator: PASSED **");
    else
      $display("** feathered_tile_blend_accumulator: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** feathered_tile_blend_accumulator: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hdl/ftba_pkg.sv
hdl/ftba_if.sv
hdl/ftba_div.sv
hdl/feathered_tile_blend_accumulator.sv
tb/sv/feathered_tile_blend_accumulator_tb.sv
